// File: design/dmwbd_pkg.sv
// Shared types, codes and constants of the direct-mapped write-back directory.
`default_nettype none

package dmwbd_pkg;

  localparam int BN_BITS      = 24;                        // block number field width
  localparam int LINE_BITS    = 6;                         // line index field width
  localparam int LINES_DEF    = 64;                        // default line count
  localparam int MOD_DIGIT    = 4;                         // bits reduced per cycle
  localparam int MOD_CYC      = BN_BITS / MOD_DIGIT;       // cycles of line reduction
  localparam int MOD_CNT_BITS = $clog2(MOD_CYC + 1);

  typedef enum logic [2:0] {
    CMD_GET        = 3'd0,
    CMD_PUT        = 3'd1,
    CMD_MARK_DIRTY = 3'd2,
    CMD_FLUSH_ONE  = 3'd3,
    CMD_FLUSH_ALL  = 3'd4
  } cmd_e_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [BN_BITS-1:0] block_number;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic [LINE_BITS-1:0] line_index;
    logic                 writeback_valid;
    logic [BN_BITS-1:0]   writeback_block;
    logic                 fill_valid;
    logic [BN_BITS-1:0]   fill_block;
    logic                 last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_RESP,
    ST_FL_RD,
    ST_FL_EMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;         // capture the input item, start line reduction
    logic rd_line;      // read the tag of the looked-up line
    logic rd_flush;     // read the tag for the flush walk
    logic lookup_emit;  // update the line and load the lookup result
    logic flush_emit;   // load the flush result of the current line and advance
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic line_ready;   // line index of the captured item is known
    logic out_free;     // output register can take a result this cycle
    logic fl_last;      // flush walk is at the final line
  } sts_t;

endpackage

`default_nettype wire

// File: design/dmwbd_ctrl.sv
// Controller state machine of the directory: sequences lookups and the flush walk.
`default_nettype none

module dmwbd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_command,
  input  wire dmwbd_pkg::sts_t   sts,
  output dmwbd_pkg::ctl_t        ctl
);

  dmwbd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmwbd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      dmwbd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          case (dmwbd_pkg::cmd_e_t'(in_command))
            dmwbd_pkg::CMD_GET,
            dmwbd_pkg::CMD_PUT,
            dmwbd_pkg::CMD_MARK_DIRTY,
            dmwbd_pkg::CMD_FLUSH_ONE:  state_nxt = dmwbd_pkg::ST_LOOK;
            dmwbd_pkg::CMD_FLUSH_ALL:  state_nxt = dmwbd_pkg::ST_FL_RD;
            default:                   state_nxt = dmwbd_pkg::ST_IDLE;
          endcase
        end
      end
      dmwbd_pkg::ST_LOOK: begin
        if (sts.line_ready) begin
          ctl.rd_line = 1'b1;
          state_nxt   = dmwbd_pkg::ST_RESP;
        end
      end
      dmwbd_pkg::ST_RESP: begin
        if (sts.out_free) begin
          ctl.lookup_emit = 1'b1;
          state_nxt       = dmwbd_pkg::ST_IDLE;
        end
      end
      dmwbd_pkg::ST_FL_RD: begin
        ctl.rd_flush = 1'b1;
        state_nxt    = dmwbd_pkg::ST_FL_EMIT;
      end
      dmwbd_pkg::ST_FL_EMIT: begin
        ctl.rd_flush = 1'b1;
        if (sts.out_free) begin
          ctl.flush_emit = 1'b1;
          if (sts.fl_last) begin
            state_nxt = dmwbd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = dmwbd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/dmwbd_dpath.sv
// Datapath of the directory: line reduction, tag memory, valid and dirty bits, result register.
`default_nettype none

module dmwbd_dpath #(
  parameter int LINES = dmwbd_pkg::LINES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dmwbd_pkg::ctl_t      ctl,
  output dmwbd_pkg::sts_t           sts,
  input  wire dmwbd_pkg::in_item_t  in_data,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output dmwbd_pkg::out_item_t      out_data
);

  localparam int LB    = $clog2(LINES);
  localparam int ACC_W = LB + 1;
  localparam int BN    = dmwbd_pkg::BN_BITS;

  logic [2:0]    cmd_r;
  logic [BN-1:0] bn_r;
  logic [LB-1:0] line_w;
  logic          line_ready;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_data.command;
      bn_r  <= in_data.block_number;
    end
  end

  // Line index: low bits for a power-of-two line count, otherwise a
  // remainder built a few bits per cycle from the top of the block number.
  if ((LINES & (LINES - 1)) == 0) begin : gen_line_mask
    logic [LB-1:0] line_r;

    always_ff @(posedge clk) begin
      if (ctl.load) begin
        line_r <= in_data.block_number[LB-1:0];
      end
    end

    assign line_w     = line_r;
    assign line_ready = 1'b1;
  end else begin : gen_line_mod
    logic [LB-1:0]                     rem_r, rem_nxt;
    logic [BN-1:0]                     sh_r;
    logic [dmwbd_pkg::MOD_CNT_BITS-1:0] cnt_r;
    logic [ACC_W-1:0]                  acc;

    always_comb begin
      acc = {1'b0, rem_r};
      for (int i = 0; i < dmwbd_pkg::MOD_DIGIT; i++) begin
        acc = {acc[LB-1:0], sh_r[BN-1-i]};
        if (acc >= ACC_W'(LINES)) begin
          acc = acc - ACC_W'(LINES);
        end
      end
      rem_nxt = acc[LB-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r <= '0;
      end else if (ctl.load) begin
        cnt_r <= dmwbd_pkg::MOD_CNT_BITS'(dmwbd_pkg::MOD_CYC);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.load) begin
        rem_r <= '0;
        sh_r  <= in_data.block_number;
      end else if (cnt_r != '0) begin
        rem_r <= rem_nxt;
        sh_r  <= sh_r << dmwbd_pkg::MOD_DIGIT;
      end
    end

    assign line_w     = rem_r;
    assign line_ready = (cnt_r == '0);
  end

  // Tag store, valid and dirty bits.
  logic [BN-1:0]    tag_mem [LINES];
  logic [BN-1:0]    tag_q_r;
  logic [LB-1:0]    rd_addr;
  logic [LINES-1:0] valid_r;
  logic [LINES-1:0] dirty_r;
  logic [LB-1:0]    fl_idx_r;
  logic             fl_last;

  assign fl_last = (fl_idx_r == LB'(LINES - 1));

  always_comb begin
    rd_addr = line_w;
    if (ctl.rd_flush) begin
      if (!ctl.flush_emit) begin
        rd_addr = fl_idx_r;
      end else if (fl_last) begin
        rd_addr = '0;
      end else begin
        rd_addr = fl_idx_r + LB'(1);
      end
    end
  end

  // Lookup result and line update.
  logic                 lk_valid, lk_dirty, lk_hit;
  logic                 lk_is_gp, lk_miss_fill, lk_dirty_nxt;
  dmwbd_pkg::cmd_e_t    lk_cmd;
  dmwbd_pkg::out_item_t lk_item, fl_item;

  always_comb begin
    lk_cmd       = dmwbd_pkg::cmd_e_t'(cmd_r);
    lk_valid     = valid_r[line_w];
    lk_dirty     = dirty_r[line_w];
    lk_hit       = lk_valid && (tag_q_r == bn_r);
    lk_is_gp     = (lk_cmd == dmwbd_pkg::CMD_GET) || (lk_cmd == dmwbd_pkg::CMD_PUT);
    lk_miss_fill = lk_is_gp && !lk_hit;
    lk_dirty_nxt = lk_dirty;
    lk_item      = '0;
    lk_item.hit        = lk_hit;
    lk_item.line_index = dmwbd_pkg::LINE_BITS'(line_w);
    lk_item.last       = 1'b1;
    case (lk_cmd)
      dmwbd_pkg::CMD_GET, dmwbd_pkg::CMD_PUT: begin
        if (!lk_hit) begin
          lk_item.writeback_valid = lk_valid && lk_dirty;
          lk_item.writeback_block = (lk_valid && lk_dirty) ? tag_q_r : '0;
          lk_item.fill_valid      = 1'b1;
          lk_item.fill_block      = bn_r;
          lk_dirty_nxt            = 1'b0;
        end
        if (lk_cmd == dmwbd_pkg::CMD_PUT) begin
          lk_dirty_nxt = 1'b1;
        end
      end
      dmwbd_pkg::CMD_MARK_DIRTY: begin
        if (lk_hit) begin
          lk_dirty_nxt = 1'b1;
        end
      end
      dmwbd_pkg::CMD_FLUSH_ONE: begin
        lk_item.writeback_valid = lk_hit && lk_dirty;
        lk_item.writeback_block = (lk_hit && lk_dirty) ? bn_r : '0;
        if (lk_hit) begin
          lk_dirty_nxt = 1'b0;
        end
      end
      default: begin
        lk_dirty_nxt = lk_dirty;
      end
    endcase

    fl_item                 = '0;
    fl_item.line_index      = dmwbd_pkg::LINE_BITS'(fl_idx_r);
    fl_item.writeback_valid = valid_r[fl_idx_r] && dirty_r[fl_idx_r];
    fl_item.writeback_block = (valid_r[fl_idx_r] && dirty_r[fl_idx_r]) ? tag_q_r : '0;
    fl_item.last            = fl_last;
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_line || ctl.rd_flush) begin
      tag_q_r <= tag_mem[rd_addr];
    end
    if (ctl.lookup_emit && lk_miss_fill) begin
      tag_mem[line_w] <= bn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
    end else if (ctl.lookup_emit) begin
      if (lk_miss_fill) begin
        valid_r[line_w] <= 1'b1;
      end
      dirty_r[line_w] <= lk_dirty_nxt;
    end else if (ctl.flush_emit) begin
      dirty_r[fl_idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      fl_idx_r <= '0;
    end else if (ctl.flush_emit) begin
      fl_idx_r <= fl_last ? '0 : fl_idx_r + LB'(1);
    end
  end

  // Result register.
  logic out_valid_r;
  dmwbd_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.lookup_emit || ctl.flush_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.lookup_emit) begin
      out_r <= lk_item;
    end else if (ctl.flush_emit) begin
      out_r <= fl_item;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_r;
  assign sts.line_ready = line_ready;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.fl_last    = fl_last;

endmodule

`default_nettype wire

// File: design/direct_mapped_write_back_directory.sv
// Top level of the direct-mapped write-back directory: controller plus datapath.
`default_nettype none

// Tag and dirty directory for a direct-mapped write-back cache of LINES lines
// (2 to 64). A block number (24 bits) maps to line block_number mod LINES.
// Each input item carries a command: get and put look the block up and, on a
// miss, report a write-back of a dirty victim under the victim's own block
// number plus a fill of the requested block; put also marks the line dirty.
// Mark-dirty sets the dirty bit on a hit only; flush-one writes back a dirty
// hit and cleans it. These four give exactly one result item with last set.
// Flush-all walks lines 0 to LINES-1, giving one result per line (last on the
// final one) and cleaning every line. Codes 5 to 7 are taken and dropped with
// no result. Results carry line_index to address an external data memory.
// Timing: one item at a time. When LINES is a power of two, a lookup occupies
// the block from acceptance to the next possible acceptance for capture, tag
// memory read, and update and result load; otherwise the line index is also
// reduced 4 bits per cycle over the block number before the tag read. Flush-all
// emits one line per cycle while the output is not stalled, paced by the single
// tag memory read port. A result waits in an output register; output stalls
// hold the controller in place. Valid and dirty bits reset to clean; tags are
// not cleared and are read only behind a set valid bit.
module direct_mapped_write_back_directory #(
  parameter int LINES = dmwbd_pkg::LINES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire dmwbd_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output dmwbd_pkg::out_item_t      out_data
);

  dmwbd_pkg::ctl_t ctl;
  dmwbd_pkg::sts_t sts;

  // Sequence each item: capture, resolve the line, read, then update and emit.
  dmwbd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_data.command),
    .sts        (sts),
    .ctl        (ctl)
  );

  // Hold tags, valid and dirty bits, and the result register.
  dmwbd_dpath #(
    .LINES (LINES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: design/dmwbd_checker.sv
// Port-level checker of the directory and its bind to the top level.
`default_nettype none

module dmwbd_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire dmwbd_pkg::in_item_t  in_data,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire dmwbd_pkg::out_item_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One item at a time: a real command closes the input the cycle after it is taken;
  // undefined codes are dropped and leave the input open.
  a_in_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.command <= dmwbd_pkg::CMD_FLUSH_ALL) |=> !in_ready)
    else $error("input taken twice in a row");

  // Only the flush walk gives non-final results, and those never hit or fill.
  a_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !out_data.hit && !out_data.fill_valid)
    else $error("non-final result with hit or fill");

  // Unused block fields read zero.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.writeback_valid || out_data.writeback_block == '0) &&
                  (out_data.fill_valid || out_data.fill_block == '0))
    else $error("unused block field not zero");

  // A hit never asks for a fill.
  a_hit_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> !out_data.fill_valid)
    else $error("fill reported on a hit");

endmodule

bind direct_mapped_write_back_directory dmwbd_checker u_dmwbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
